// ===== rtl/vgbi_pkg.sv =====
// ============================================================================
// vgbi_pkg
// Shared types and constants of the vector grid bilinear interpolator.
// ============================================================================
package vgbi_pkg;

    // Fixed field widths of the stream payloads.
    localparam int VAL_BITS      = 32;
    localparam int COORD_BITS    = 25;
    localparam int ROW_FIELD_W   = 8;
    localparam int COL_FIELD_W   = 9;
    localparam int IN_TDATA_W    = 168;
    localparam int OUT_TDATA_W   = 96;
    localparam int NODE_DATA_W   = 3 * VAL_BITS;

    // Bit offsets inside s_tdata.
    localparam int OFS_ROW = 0;
    localparam int OFS_COL = 8;
    localparam int OFS_X   = 17;
    localparam int OFS_LON = 113;
    localparam int OFS_LAT = 138;

    // Grid geometry and arithmetic defaults.
    localparam int DEF_LAT_ROWS   = 181;
    localparam int DEF_LON_COLS   = 361;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int VALUE_WIDTH    = 32;
    localparam int LON_ORIGIN_DEG = 180;
    localparam int LAT_ORIGIN_DEG = 90;

    // Queue depths.
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    // Request kinds carried on s_tuser.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Control part of one queued request.
    typedef struct packed {
        logic is_query;
        logic in_range;
        logic fu_nz;
        logic fv_nz;
    } vgbi_ctl_t;

endpackage

// ===== rtl/vgbi_ram.sv =====
// ============================================================================
// vgbi_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module vgbi_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16471
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/vgbi_fifo.sv =====
// ============================================================================
// vgbi_fifo
// Small register-based first-in first-out queue with valid/ready sides.
// ============================================================================
module vgbi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != CW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/vgbi_front.sv =====
// ============================================================================
// vgbi_front
// Accepts requests, range-checks loads and clamps and splits query points.
// ============================================================================
module vgbi_front import vgbi_pkg::*; #(
    parameter int LAT_ROWS  = DEF_LAT_ROWS,
    parameter int LON_COLS  = DEF_LON_COLS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_TDATA_W-1:0]       s_tdata,
    input  logic                        s_tuser,
    output logic                        q_valid,
    input  logic                        q_ready,
    output vgbi_ctl_t                   q_ctl,
    output logic [$clog2(LAT_ROWS)-1:0] q_row,
    output logic [$clog2(LON_COLS)-1:0] q_col,
    output logic [FRAC_BITS-1:0]        q_fu,
    output logic [FRAC_BITS-1:0]        q_fv,
    output logic [NODE_DATA_W-1:0]      q_data
);

    localparam int RW  = $clog2(LAT_ROWS);
    localparam int CIW = $clog2(LON_COLS);
    localparam int CW  = (FRAC_BITS + 10 > 27) ? FRAC_BITS + 10 : 27;
    localparam logic signed [CW-1:0] LON_OFS =
        CW'(longint'(LON_ORIGIN_DEG) << FRAC_BITS);
    localparam logic signed [CW-1:0] LAT_OFS =
        CW'(longint'(LAT_ORIGIN_DEG) << FRAC_BITS);
    localparam logic signed [CW-1:0] LON_HI =
        CW'(longint'(LON_COLS - 1) << FRAC_BITS);
    localparam logic signed [CW-1:0] LAT_HI =
        CW'(longint'(LAT_ROWS - 1) << FRAC_BITS);

    logic                     valid_reg;
    vgbi_ctl_t                ctl_reg, ctl_next;
    logic [RW-1:0]            row_reg, row_next;
    logic [CIW-1:0]           col_reg, col_next;
    logic [FRAC_BITS-1:0]     fu_reg, fu_next;
    logic [FRAC_BITS-1:0]     fv_reg, fv_next;
    logic [NODE_DATA_W-1:0]   data_reg;

    logic [ROW_FIELD_W-1:0]   f_row;
    logic [COL_FIELD_W-1:0]   f_col;
    logic signed [COORD_BITS-1:0] f_lon, f_lat;
    logic signed [CW-1:0]     lon_c, lat_c;
    logic                     accept;

    assign f_row    = s_tdata[OFS_ROW +: ROW_FIELD_W];
    assign f_col    = s_tdata[OFS_COL +: COL_FIELD_W];
    assign f_lon    = s_tdata[OFS_LON +: COORD_BITS];
    assign f_lat    = s_tdata[OFS_LAT +: COORD_BITS];
    assign s_tready = !valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;

    // Offset to the grid origin and clamp to the grid extent.
    always_comb begin
        lon_c = CW'(f_lon) + LON_OFS;
        lat_c = CW'(f_lat) + LAT_OFS;
        if (lon_c < 0) begin
            lon_c = '0;
        end else if (lon_c > LON_HI) begin
            lon_c = LON_HI;
        end
        if (lat_c < 0) begin
            lat_c = '0;
        end else if (lat_c > LAT_HI) begin
            lat_c = LAT_HI;
        end
    end

    always_comb begin
        ctl_next.is_query = (s_tuser == MODE_QUERY);
        ctl_next.in_range = (32'(f_row) < LAT_ROWS) && (32'(f_col) < LON_COLS);
        fu_next           = lon_c[FRAC_BITS-1:0];
        fv_next           = lat_c[FRAC_BITS-1:0];
        ctl_next.fu_nz    = (fu_next != '0);
        ctl_next.fv_nz    = (fv_next != '0);
        if (ctl_next.is_query) begin
            row_next = lat_c[FRAC_BITS +: RW];
            col_next = lon_c[FRAC_BITS +: CIW];
        end else begin
            row_next = f_row[RW-1:0];
            col_next = f_col[CIW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctl_reg  <= ctl_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            fu_reg   <= fu_next;
            fv_reg   <= fv_next;
            data_reg <= s_tdata[OFS_X +: NODE_DATA_W];
        end
    end

    assign q_valid = valid_reg;
    assign q_ctl   = ctl_reg;
    assign q_row   = row_reg;
    assign q_col   = col_reg;
    assign q_fu    = fu_reg;
    assign q_fv    = fv_reg;
    assign q_data  = data_reg;

endmodule

// ===== rtl/vgbi_back.sv =====
// ============================================================================
// vgbi_back
// Banked grid storage, bilinear blend pipeline and result queue.
// ============================================================================
module vgbi_back import vgbi_pkg::*; #(
    parameter int LAT_ROWS  = DEF_LAT_ROWS,
    parameter int LON_COLS  = DEF_LON_COLS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  vgbi_ctl_t                   cmd_ctl,
    input  logic [$clog2(LAT_ROWS)-1:0] cmd_row,
    input  logic [$clog2(LON_COLS)-1:0] cmd_col,
    input  logic [FRAC_BITS-1:0]        cmd_fu,
    input  logic [FRAC_BITS-1:0]        cmd_fv,
    input  logic [NODE_DATA_W-1:0]      cmd_data,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int RW   = $clog2(LAT_ROWS);
    localparam int CIW  = $clog2(LON_COLS);
    localparam int HR   = (LAT_ROWS + 1) / 2;
    localparam int HC   = (LON_COLS + 1) / 2;
    localparam int BD   = HR * HC;
    localparam int BAW  = $clog2(BD);
    localparam int WW   = FRAC_BITS + 1;
    localparam int PW   = VAL_BITS + FRAC_BITS + 1;
    localparam int SW   = VAL_BITS + 2 * FRAC_BITS + 2;
    localparam int TW   = VAL_BITS + 2;
    localparam int OCW  = $clog2(OUT_DEPTH + 1);
    localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;
    localparam logic signed [SW-1:0] HALF = SW'(1) << (2 * FRAC_BITS - 1);
    localparam longint SAT_HI = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (VALUE_WIDTH - 1));

    // ---------------------------------------------------------------- issue
    logic [OCW-1:0]         credit_reg, credit_next;
    logic                   credit_ok, fire, qfire, m_fire;
    logic [BAW-1:0]         bank_addr [4];
    logic [3:0]             bank_we;
    logic [NODE_DATA_W-1:0] bank_rdata [4];
    logic [RW:0]            r_sel [4];
    logic [CIW:0]           c_sel [4];
    logic [31:0]            lin [4];

    assign credit_ok = (credit_reg != OCW'(OUT_DEPTH));
    assign cmd_ready = !cmd_ctl.is_query || credit_ok;
    assign fire      = cmd_valid && cmd_ready;
    assign qfire     = fire && cmd_ctl.is_query;

    // Bank {row parity, column parity}; each of the four neighbors lands
    // in a different bank, so one read per bank covers a query.
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            r_sel[b] = {1'b0, cmd_row} + (RW + 1)'(cmd_row[0] ^ b[1]);
            c_sel[b] = {1'b0, cmd_col} + (CIW + 1)'(cmd_col[0] ^ b[0]);
            lin[b]   = 32'(r_sel[b][RW:1]) * 32'(HC) + 32'(c_sel[b][CIW:1]);
            bank_addr[b] = lin[b][BAW-1:0];
            bank_we[b]   = fire && !cmd_ctl.is_query && cmd_ctl.in_range
                           && (cmd_row[0] == b[1]) && (cmd_col[0] == b[0]);
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        vgbi_ram #(
            .WIDTH (NODE_DATA_W),
            .DEPTH (BD)
        ) u_ram (
            .aclk  (aclk),
            .we    (bank_we[b]),
            .waddr (bank_addr[b]),
            .wdata (cmd_data),
            .raddr (bank_addr[b]),
            .rdata (bank_rdata[b])
        );
    end

    // ------------------------------------------------------------- pipeline
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 ip1_reg, jp1_reg, fu_nz1_reg, fv_nz1_reg;
    logic [FRAC_BITS-1:0] fu1_reg, fv1_reg, fv2_reg, fv3_reg;
    logic signed [PW-1:0] prod_reg [3][4];
    logic signed [PW-1:0] a_reg [3][2];
    logic signed [SW-1:0] m_reg [3][2];
    logic [NODE_DATA_W-1:0] nb [4];
    logic [WW-1:0]        wu0, wu1, wv0, wv1;
    logic [OUT_TDATA_W-1:0] res_data;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            nb[k] = bank_rdata[{ip1_reg ^ k[1], jp1_reg ^ k[0]}];
        end
        // A neighbor with zero weight is replaced by zero.
        if (!fu_nz1_reg) begin
            nb[1] = '0;
            nb[3] = '0;
        end
        if (!fv_nz1_reg) begin
            nb[2] = '0;
            nb[3] = '0;
        end
        wu1 = {1'b0, fu1_reg};
        wu0 = ONE - wu1;
        wv1 = {1'b0, fv3_reg};
        wv0 = ONE - wv1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= qfire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ip1_reg    <= cmd_row[0];
        jp1_reg    <= cmd_col[0];
        fu_nz1_reg <= cmd_ctl.fu_nz;
        fv_nz1_reg <= cmd_ctl.fv_nz;
        fu1_reg    <= cmd_fu;
        fv1_reg    <= cmd_fv;
        fv2_reg    <= fv1_reg;
        fv3_reg    <= fv2_reg;
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 4; k++) begin
                prod_reg[c][k] <=
                    PW'($signed(nb[k][c * VAL_BITS +: VAL_BITS])) *
                    PW'($signed({1'b0, (k[0] ? wu1 : wu0)}));
            end
            a_reg[c][0] <= prod_reg[c][0] + prod_reg[c][1];
            a_reg[c][1] <= prod_reg[c][2] + prod_reg[c][3];
            m_reg[c][0] <= SW'(a_reg[c][0]) * SW'($signed({1'b0, wv0}));
            m_reg[c][1] <= SW'(a_reg[c][1]) * SW'($signed({1'b0, wv1}));
        end
    end

    // Round to nearest (ties up) and saturate.
    always_comb begin
        logic signed [SW-1:0] s;
        logic signed [TW-1:0] t;
        longint               tl;
        res_data = '0;
        for (int c = 0; c < 3; c++) begin
            s  = m_reg[c][0] + m_reg[c][1] + HALF;
            t  = TW'(s >>> (2 * FRAC_BITS));
            tl = longint'(t);
            if (tl < SAT_LO) begin
                tl = SAT_LO;
            end else if (tl > SAT_HI) begin
                tl = SAT_HI;
            end
            res_data[c * VAL_BITS +: VAL_BITS] = tl[VAL_BITS-1:0];
        end
    end

    // ----------------------------------------------------------- result side
    logic res_ready;

    vgbi_fifo #(
        .WIDTH (OUT_TDATA_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v4_reg && res_ready),
        .in_ready  (res_ready),
        .in_data   (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // Credits cover queries in the pipeline plus those waiting in the queue,
    // so res_ready is always high when a result arrives.
    assign m_fire = m_tvalid && m_tready;

    always_comb begin
        credit_next = credit_reg;
        if (qfire && !m_fire) begin
            credit_next = credit_reg + OCW'(1);
        end else if (m_fire && !qfire) begin
            credit_next = credit_reg - OCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

endmodule

// ===== rtl/vector_grid_bilinear_interpolator_core.sv =====
// ============================================================================
// vector_grid_bilinear_interpolator_core
// Bilinear interpolation of three-component vectors over a one-degree grid.
// ============================================================================
// The block holds a LAT_ROWS by LON_COLS grid of x/y/z nodes (row 0 at -90
// degrees latitude, column 0 at -180 degrees longitude). A request with
// s_tuser low loads one node; a request with s_tuser high is a query whose
// longitude and latitude carry FRAC_BITS fraction bits. Each query yields one
// result with the bilinear blend of its four surrounding nodes, rounded to
// nearest and saturated; loads yield nothing. One request is taken per clock
// cycle in sustained operation, loads and queries mixed freely, while result
// credits and m_tready allow. A query passes the front register, the request
// queue, the bank read, the weight products, sums and row blend, then the
// result queue behind m_tvalid. The rate comes from the grid being split by
// row and column parity into four RAM banks, each read once per cycle, so all
// four neighbors are fetched together. The grid comes out of reset unwritten
// and needs no clearing pass; querying a node with nonzero weight that was
// never loaded gives an undefined result. Loads outside the grid are dropped.
// ============================================================================
module vector_grid_bilinear_interpolator_core import vgbi_pkg::*; #(
    parameter int LAT_ROWS  = DEF_LAT_ROWS,
    parameter int LON_COLS  = DEF_LON_COLS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata, lowest bit up: node_row[8], node_col[9], node_x[32],
    // node_y[32], node_z[32], query_lon[25], query_lat[25], zero fill[5]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: mode (0 load, 1 query)
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata, lowest bit up: value_x[32], value_y[32], value_z[32]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int RW    = $clog2(LAT_ROWS);
    localparam int CIW   = $clog2(LON_COLS);
    localparam int CTL_W = $bits(vgbi_ctl_t);
    localparam int QW    = CTL_W + RW + CIW + 2 * FRAC_BITS + NODE_DATA_W;

    // Front side: classified requests.
    logic                   f_valid, f_ready;
    vgbi_ctl_t              f_ctl;
    logic [RW-1:0]          f_row;
    logic [CIW-1:0]         f_col;
    logic [FRAC_BITS-1:0]   f_fu, f_fv;
    logic [NODE_DATA_W-1:0] f_data;

    // Back side: requests out of the queue.
    logic                   b_valid, b_ready;
    logic [QW-1:0]          b_word;
    vgbi_ctl_t              b_ctl;
    logic [RW-1:0]          b_row;
    logic [CIW-1:0]         b_col;
    logic [FRAC_BITS-1:0]   b_fu, b_fv;
    logic [NODE_DATA_W-1:0] b_data;

    vgbi_front #(
        .LAT_ROWS  (LAT_ROWS),
        .LON_COLS  (LON_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_ctl    (f_ctl),
        .q_row    (f_row),
        .q_col    (f_col),
        .q_fu     (f_fu),
        .q_fv     (f_fv),
        .q_data   (f_data)
    );

    // The queue lets the front keep taking requests while the back waits
    // for result credits, and the other way round.
    vgbi_fifo #(
        .WIDTH (QW),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_ctl, f_row, f_col, f_fu, f_fv, f_data}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_word)
    );

    assign {b_ctl, b_row, b_col, b_fu, b_fv, b_data} = b_word;

    vgbi_back #(
        .LAT_ROWS  (LAT_ROWS),
        .LON_COLS  (LON_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd_ctl   (b_ctl),
        .cmd_row   (b_row),
        .cmd_col   (b_col),
        .cmd_fu    (b_fu),
        .cmd_fv    (b_fv),
        .cmd_data  (b_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
